[design/rgb_to_hsv_pixel_defines.svh]
// Assertion macros shared by the pixel converter checkers.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel converter check failed");

// Consequent must hold in the cycle after the antecedent.
`define HSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel converter check failed");

`endif

[design/hsv_pkg.sv]
// Shared widths and the divider lane record of the RGB to HSV converter.
// No dependencies.
package hsv_pkg;

  localparam int CH_W       = 8;   // channel and result width
  localparam int M_W        = 11;  // sector numerator / 60, below 6*chroma
  localparam int SAT_REM_W  = 16;  // 255 * chroma
  localparam int HUE_REM_W  = 17;  // 85 * numerator
  localparam int HUE_DIV_W  = CH_W + 1; // 2 * chroma
  localparam int DIV_STEPS  = CH_W;     // one quotient bit per stage

  typedef struct packed {
    logic [SAT_REM_W-1:0] sat_rem;
    logic [CH_W-1:0]      sat_div;
    logic [CH_W-1:0]      sat_q;
    logic [HUE_REM_W-1:0] hue_rem;
    logic [HUE_DIV_W-1:0] hue_div;
    logic [CH_W-1:0]      hue_q;
    logic [CH_W-1:0]      bright;
  } div_lane_t;

endpackage

[design/hsv_ifs.sv]
// Valid/ready channel interfaces for pixels in and HSV results out.
// Depends on hsv_pkg.
interface hsv_rgb_if;
  import hsv_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface hsv_res_if;
  import hsv_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] hue;
  logic [CH_W-1:0] saturation;
  logic [CH_W-1:0] brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

[design/hsv_front.sv]
// Front end: max/min and sector pick, then chroma, numerators and divisors.
// Two register stages; depends on hsv_pkg.
module hsv_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [hsv_pkg::CH_W-1:0] in_red,
  input  logic [hsv_pkg::CH_W-1:0] in_green,
  input  logic [hsv_pkg::CH_W-1:0] in_blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hsv_pkg::div_lane_t       out_lane
);
  import hsv_pkg::*;

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  logic [CH_W-1:0] r_r, g_r, b_r, mx_r, mn_r;
  sector_t         sec_r;
  logic            v1_r, v2_r;
  logic            rdy1, rdy2;

  logic [CH_W-1:0] mx_nxt, mn_nxt;
  sector_t         sec_nxt;

  logic [CH_W-1:0] chroma;
  logic [M_W-1:0]  m_num;
  div_lane_t       lane_nxt, lane_r;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  // Take no request while reset is held
  assign in_ready = rdy1 && rst_n;

  // Stage 1: largest and smallest channel; blue wins ties over green, green over red
  always_comb begin
    mx_nxt = in_red;
    mn_nxt = in_red;
    if (in_green > mx_nxt) mx_nxt = in_green;
    if (in_blue  > mx_nxt) mx_nxt = in_blue;
    if (in_green < mn_nxt) mn_nxt = in_green;
    if (in_blue  < mn_nxt) mn_nxt = in_blue;
    if (mx_nxt == in_blue)       sec_nxt = SEC_BLUE;
    else if (mx_nxt == in_green) sec_nxt = SEC_GREEN;
    else                         sec_nxt = SEC_RED;
  end

  // Stage 2: numerator over 60 (wraps modulo 2^M_W, final value is non-negative)
  always_comb begin
    chroma = mx_r - mn_r;
    case (sec_r)
      SEC_BLUE:  m_num = (M_W'(chroma) << 2) + M_W'(r_r) - M_W'(g_r);
      SEC_GREEN: m_num = (M_W'(chroma) << 1) + M_W'(b_r) - M_W'(r_r);
      SEC_RED: begin
        if (g_r >= b_r) m_num = M_W'(g_r) - M_W'(b_r);
        else            m_num = M_W'(chroma) * M_W'(6) + M_W'(g_r) - M_W'(b_r);
      end
      default:   m_num = '0;
    endcase
    // 255*C/mx, and 255*60*M/(360*C) = 85*M/(2*C)
    lane_nxt.sat_rem = (SAT_REM_W'(chroma) << 8) - SAT_REM_W'(chroma);
    lane_nxt.sat_div = (mx_r == '0) ? CH_W'(1) : mx_r;
    lane_nxt.sat_q   = '0;
    lane_nxt.hue_rem = (HUE_REM_W'(m_num) << 6) + (HUE_REM_W'(m_num) << 4)
                     + (HUE_REM_W'(m_num) << 2) + HUE_REM_W'(m_num);
    lane_nxt.hue_div = (chroma == '0) ? HUE_DIV_W'(1) : {chroma, 1'b0};
    lane_nxt.hue_q   = '0;
    lane_nxt.bright  = mx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
    if (rdy1 && in_valid) begin
      r_r   <= in_red;
      g_r   <= in_green;
      b_r   <= in_blue;
      mx_r  <= mx_nxt;
      mn_r  <= mn_nxt;
      sec_r <= sec_nxt;
    end
    if (rdy2 && v1_r) lane_r <= lane_nxt;
  end

  assign out_valid = v2_r;
  assign out_lane  = lane_r;

endmodule

[design/hsv_div.sv]
// Pipelined restoring divider: one quotient bit of saturation and hue per stage.
// Depends on hsv_pkg.
module hsv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsv_pkg::div_lane_t in_lane,
  output logic               out_valid,
  input  logic               out_ready,
  output hsv_pkg::div_lane_t out_lane
);
  import hsv_pkg::*;

  div_lane_t chain [0:DIV_STEPS];
  logic      chain_v [0:DIV_STEPS];
  logic      chain_rdy [0:DIV_STEPS];

  assign chain[0]             = in_lane;
  assign chain_v[0]           = in_valid;
  assign chain_rdy[DIV_STEPS] = out_ready;
  assign in_ready             = chain_rdy[0];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int QB = DIV_STEPS - 1 - s;

    div_lane_t            lane_r, lane_nxt;
    logic                 v_r;
    logic [SAT_REM_W-1:0] sat_cmp;
    logic [HUE_REM_W-1:0] hue_cmp;

    assign sat_cmp      = SAT_REM_W'(chain[s].sat_div) << QB;
    assign hue_cmp      = HUE_REM_W'(chain[s].hue_div) << QB;
    assign chain_rdy[s] = !v_r || chain_rdy[s+1];

    always_comb begin
      lane_nxt = chain[s];
      if (chain[s].sat_rem >= sat_cmp) begin
        lane_nxt.sat_rem   = chain[s].sat_rem - sat_cmp;
        lane_nxt.sat_q[QB] = 1'b1;
      end
      if (chain[s].hue_rem >= hue_cmp) begin
        lane_nxt.hue_rem   = chain[s].hue_rem - hue_cmp;
        lane_nxt.hue_q[QB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (chain_rdy[s]) begin
        v_r <= chain_v[s];
      end
      if (chain_rdy[s] && chain_v[s]) lane_r <= lane_nxt;
    end

    assign chain[s+1]   = lane_r;
    assign chain_v[s+1] = v_r;
  end

  assign out_valid = chain_v[DIV_STEPS];
  assign out_lane  = chain[DIV_STEPS];

endmodule

[design/rgb_to_hsv_pixel.sv]
// Top level of the 8-bit RGB to HSV pixel converter.
// Depends on hsv_pkg, hsv_ifs, hsv_front and hsv_div.
//
//   channel   dir  handshake           payload
//   in_pix    in   valid / ready       red, green, blue (8 bits each)
//   out_pix   out  valid / ready       hue, saturation, brightness (8 bits each)
//
// Throughput: one pixel per clock while the output is not blocked. The path
// from request to result runs through two front stages and then eight restoring
// divider stages, each of which resolves one quotient bit of saturation and of hue.
// Reset clears the valid bits only and holds the input off; the block takes a
// request in the first cycle after reset.
// Stalls: a stage holds its request while the next one is full and blocked;
// empty stages still advance, so bubbles close up and the input keeps taking
// requests while a finished result waits at the output, until every stage is full.
module rgb_to_hsv_pixel (
  input  logic        clk,
  input  logic        rst_n,
  hsv_rgb_if.sink     in_pix,
  hsv_res_if.source   out_pix
);
  import hsv_pkg::*;

  // Front to divider hand-off
  logic      mid_valid;
  logic      mid_ready;
  div_lane_t mid_lane;
  div_lane_t res_lane;

  // Max/min, sector and numerators
  hsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_red    (in_pix.red),
    .in_green  (in_pix.green),
    .in_blue   (in_pix.blue),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_lane  (mid_lane)
  );

  // Both quotients, one bit per stage; the last stage is the output register
  hsv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_lane   (mid_lane),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .out_lane  (res_lane)
  );

  assign out_pix.hue        = res_lane.hue_q;
  assign out_pix.saturation = res_lane.sat_q;
  assign out_pix.brightness = res_lane.bright;

endmodule

[design/hsv_checker.sv]
// Port-level checks on the converter's result channel, bound to the top level.
// Depends on hsv_pkg and rgb_to_hsv_pixel_defines.svh.
`include "rgb_to_hsv_pixel_defines.svh"

module hsv_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [hsv_pkg::CH_W-1:0] out_hue,
  input logic [hsv_pkg::CH_W-1:0] out_saturation,
  input logic [hsv_pkg::CH_W-1:0] out_brightness
);
  import hsv_pkg::*;

  // A stalled result holds
  `HSV_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_hue) && $stable(out_saturation) && $stable(out_brightness))
  // Hue tops out below a full turn
  `HSV_ASSERT_NOW(a_hue_range, out_valid, out_hue != {CH_W{1'b1}})
  // Black gives zero saturation and zero hue
  `HSV_ASSERT_NOW(a_black, out_valid && out_brightness == '0, out_saturation == '0 && out_hue == '0)
  // Grey gives zero hue
  `HSV_ASSERT_NOW(a_grey, out_valid && out_saturation == '0, out_hue == '0)

endmodule

bind rgb_to_hsv_pixel hsv_checker u_hsv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_pix.valid),
  .out_ready      (out_pix.ready),
  .out_hue        (out_pix.hue),
  .out_saturation (out_pix.saturation),
  .out_brightness (out_pix.brightness)
);
